### rtl/wwcmp_pkg.sv
// Shared types and constants for the weighted walk count matrix power unit.
`timescale 1ns / 1ps
`default_nettype none
package wwcmp_pkg;

   localparam int unsigned WALK_MOD_VAL = 2009;
   localparam logic [10:0] WALK_MOD     = 11'd2009;
   localparam int unsigned ENTRY_W      = 11;
   localparam int unsigned PROD_W       = 2 * ENTRY_W;
   localparam int unsigned ACC_W        = 31;
   localparam int unsigned BARRETT_SHIFT = 41;
   localparam logic [30:0] BARRETT_MUL  = 31'((64'd1 << BARRETT_SHIFT) / 64'd2009);
   localparam int unsigned RED_W        = ACC_W + 31;
   localparam int unsigned QUOT_W       = RED_W - BARRETT_SHIFT;

   localparam int unsigned NODE_W       = 4;
   localparam int unsigned LEN_W        = 4;
   localparam int unsigned NCOUNT_W     = 5;
   localparam int unsigned PLEN_W       = 30;

   localparam logic CSR_NODE_COUNT  = 1'b0;
   localparam logic CSR_PATH_LENGTH = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BUILD,
      ST_BUILD_DRAIN,
      ST_EXP_TOP,
      ST_EXP_SHIFT,
      ST_MM_RUN,
      ST_MM_DRAIN,
      ST_RED_MUL,
      ST_RED_QUOT,
      ST_RED_WRITE,
      ST_CP_RUN,
      ST_CP_DRAIN,
      ST_RES_READ,
      ST_RES_OUT
   } state_type;

endpackage
`default_nettype wire

### rtl/weighted_walk_count_matrix_power_unit.sv
// Walk counter: loads graph cells, raises the expanded adjacency matrix to a power.
//
//  channel | ports                 | payload
//  --------+-----------------------+------------------------------------------------
//  req     | req_tvalid/tready     | tdata: from_node, to_node, edge_length; tlast
//  rsp     | rsp_tvalid/tready     | tdata: walk_count
//  csr     | csr_we/index/wdata    | 0: node_count, 1: path_length
//
// Cells are taken one per cycle while the unit is idle. A cell with tlast starts the computation:
// the matrices are built (m = node_count*CHAIN_COPIES, node_count clamped to 1..MAX_NODES), then
// each matrix product runs on one multiply-accumulate fed by the matrix memories,
// followed by a copy sweep; one product per set bit and one per bit above the lowest.
// Reset is synchronous and clears control state and the weight valid bits.
// A pending result holds in the output register while the input is open again.
`timescale 1ns / 1ps
`default_nettype none
module weighted_walk_count_matrix_power_unit #(
   parameter int MAX_NODES    = 16,
   parameter int CHAIN_COPIES = 9
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,   // [3:0] from_node, [7:4] to_node, [11:8] edge_length
   input  wire         req_tlast,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,   // [10:0] walk_count
   input  wire         csr_we,
   input  wire         csr_index,
   input  wire  [29:0] csr_wdata
);

   localparam int DIM  = MAX_NODES * CHAIN_COPIES;
   localparam int NIW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int NCW  = $clog2(MAX_NODES + 1);
   localparam int CIW  = (CHAIN_COPIES > 1) ? $clog2(CHAIN_COPIES) : 1;
   localparam int IW   = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int MW   = $clog2(DIM + 1);
   localparam int AW   = (DIM > 1) ? $clog2(DIM * DIM) : 1;
   localparam int WD   = MAX_NODES * MAX_NODES;
   localparam int WIW  = (WD > 1) ? $clog2(WD) : 1;
   localparam int EW   = wwcmp_pkg::ENTRY_W;

   // configuration
   logic [wwcmp_pkg::NCOUNT_W-1:0] node_count_ff;
   logic [wwcmp_pkg::PLEN_W-1:0]   path_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff  <= wwcmp_pkg::NCOUNT_W'(1);
         path_length_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            wwcmp_pkg::CSR_NODE_COUNT:  node_count_ff  <= csr_wdata[wwcmp_pkg::NCOUNT_W-1:0];
            wwcmp_pkg::CSR_PATH_LENGTH: path_length_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective node count and expanded dimension
   logic [NCW-1:0] n_eff;
   logic [MW-1:0]  m_dim;
   always_comb begin
      if (node_count_ff == '0)
         n_eff = NCW'(1);
      else if (32'(node_count_ff) > MAX_NODES)
         n_eff = NCW'(MAX_NODES);
      else
         n_eff = NCW'(node_count_ff);
      m_dim = MW'(32'(n_eff) * CHAIN_COPIES);
   end

   logic [NIW-1:0] n_last;
   logic [IW-1:0]  m_last;
   assign n_last = NIW'(n_eff - NCW'(1));
   assign m_last = IW'(m_dim - MW'(1));

   // input fields
   logic [wwcmp_pkg::NODE_W-1:0] in_from;
   logic [wwcmp_pkg::NODE_W-1:0] in_to;
   logic [wwcmp_pkg::LEN_W-1:0]  in_len;
   assign in_from = req_tdata[3:0];
   assign in_to   = req_tdata[7:4];
   assign in_len  = req_tdata[11:8];

   // FSM and counters
   wwcmp_pkg::state_type state_ff, state_in;
   logic [IW-1:0]   r_ff, r_in, c_ff, c_in, k_ff, k_in;
   logic [AW-1:0]   r_base_ff, r_base_in, k_base_ff, k_base_in;
   logic [CIW-1:0]  bj_ff, bj_in, bk_ff, bk_in;
   logic [NIW-1:0]  bu_ff, bu_in, bv_ff, bv_in;
   logic [wwcmp_pkg::PLEN_W-1:0] exp_ff, exp_in;
   logic            op_sq_ff, op_sq_in;
   logic            rsp_load;
   logic            accept;

   assign req_tready = (state_ff == wwcmp_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wwcmp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff      <= r_in;
      c_ff      <= c_in;
      k_ff      <= k_in;
      r_base_ff <= r_base_in;
      k_base_ff <= k_base_in;
      bj_ff     <= bj_in;
      bk_ff     <= bk_in;
      bu_ff     <= bu_in;
      bv_ff     <= bv_in;
      exp_ff    <= exp_in;
      op_sq_ff  <= op_sq_in;
   end

   // datapath registers read by the FSM
   logic rv1_ff, pv_ff;
   logic rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      r_in      = r_ff;
      c_in      = c_ff;
      k_in      = k_ff;
      r_base_in = r_base_ff;
      k_base_in = k_base_ff;
      bj_in     = bj_ff;
      bk_in     = bk_ff;
      bu_in     = bu_ff;
      bv_in     = bv_ff;
      exp_in    = exp_ff;
      op_sq_in  = op_sq_ff;
      rsp_load  = 1'b0;
      case (state_ff)
         wwcmp_pkg::ST_IDLE: begin
            r_in = '0; c_in = '0; k_in = '0; r_base_in = '0; k_base_in = '0;
            bj_in = '0; bk_in = '0; bu_in = '0; bv_in = '0;
            if (accept && req_tlast) begin
               exp_in   = path_length_ff;
               state_in = wwcmp_pkg::ST_BUILD;
            end
         end
         wwcmp_pkg::ST_BUILD: begin
            // columns run (chain copy, node), rows likewise
            if (bv_ff == n_last) begin
               bv_in = '0;
               if (bk_ff == CIW'(CHAIN_COPIES - 1)) begin
                  bk_in = '0;
                  c_in  = '0;
                  r_in      = r_ff + IW'(1);
                  r_base_in = r_base_ff + AW'(DIM);
                  if (bu_ff == n_last) begin
                     bu_in = '0;
                     if (bj_ff == CIW'(CHAIN_COPIES - 1)) begin
                        state_in = wwcmp_pkg::ST_BUILD_DRAIN;
                     end else begin
                        bj_in = bj_ff + CIW'(1);
                     end
                  end else begin
                     bu_in = bu_ff + NIW'(1);
                  end
               end else begin
                  bk_in = bk_ff + CIW'(1);
                  c_in  = c_ff + IW'(1);
               end
            end else begin
               bv_in = bv_ff + NIW'(1);
               c_in  = c_ff + IW'(1);
            end
         end
         wwcmp_pkg::ST_BUILD_DRAIN: begin
            state_in = wwcmp_pkg::ST_EXP_TOP;
         end
         wwcmp_pkg::ST_EXP_TOP: begin
            r_in = '0; c_in = '0; k_in = '0; r_base_in = '0; k_base_in = '0;
            if (exp_ff == '0) begin
               state_in = wwcmp_pkg::ST_RES_READ;
            end else if (exp_ff[0]) begin
               op_sq_in = 1'b0;
               state_in = wwcmp_pkg::ST_MM_RUN;
            end else begin
               state_in = wwcmp_pkg::ST_EXP_SHIFT;
            end
         end
         wwcmp_pkg::ST_EXP_SHIFT: begin
            r_in = '0; c_in = '0; k_in = '0; r_base_in = '0; k_base_in = '0;
            exp_in = exp_ff >> 1;
            if ((exp_ff >> 1) != '0) begin
               op_sq_in = 1'b1;
               state_in = wwcmp_pkg::ST_MM_RUN;
            end else begin
               state_in = wwcmp_pkg::ST_EXP_TOP;
            end
         end
         wwcmp_pkg::ST_MM_RUN: begin
            if (k_ff == m_last) begin
               state_in = wwcmp_pkg::ST_MM_DRAIN;
            end else begin
               k_in      = k_ff + IW'(1);
               k_base_in = k_base_ff + AW'(DIM);
            end
         end
         wwcmp_pkg::ST_MM_DRAIN: begin
            if (!rv1_ff && !pv_ff) state_in = wwcmp_pkg::ST_RED_MUL;
         end
         wwcmp_pkg::ST_RED_MUL: begin
            state_in = wwcmp_pkg::ST_RED_QUOT;
         end
         wwcmp_pkg::ST_RED_QUOT: begin
            state_in = wwcmp_pkg::ST_RED_WRITE;
         end
         wwcmp_pkg::ST_RED_WRITE: begin
            k_in = '0;
            k_base_in = '0;
            state_in = wwcmp_pkg::ST_MM_RUN;
            if (c_ff == m_last) begin
               c_in = '0;
               r_in      = r_ff + IW'(1);
               r_base_in = r_base_ff + AW'(DIM);
               if (r_ff == m_last) begin
                  r_in      = '0;
                  r_base_in = '0;
                  state_in  = wwcmp_pkg::ST_CP_RUN;
               end
            end else begin
               c_in = c_ff + IW'(1);
            end
         end
         wwcmp_pkg::ST_CP_RUN: begin
            if (c_ff == m_last) begin
               c_in = '0;
               r_in      = r_ff + IW'(1);
               r_base_in = r_base_ff + AW'(DIM);
               if (r_ff == m_last) state_in = wwcmp_pkg::ST_CP_DRAIN;
            end else begin
               c_in = c_ff + IW'(1);
            end
         end
         wwcmp_pkg::ST_CP_DRAIN: begin
            state_in = op_sq_ff ? wwcmp_pkg::ST_EXP_TOP : wwcmp_pkg::ST_EXP_SHIFT;
         end
         wwcmp_pkg::ST_RES_READ: begin
            state_in = wwcmp_pkg::ST_RES_OUT;
         end
         wwcmp_pkg::ST_RES_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = wwcmp_pkg::ST_IDLE;
            end
         end
         default: state_in = wwcmp_pkg::ST_IDLE;
      endcase
   end

   // weight store with valid bits
   logic [wwcmp_pkg::LEN_W-1:0] weight_mem [WD];
   logic [WD-1:0]               wvalid_ff;
   logic [wwcmp_pkg::LEN_W-1:0] w_rd_ff;
   logic                        wv_rd_ff;
   logic                        w_we;
   logic [WIW-1:0]              w_wa, w_ra;

   assign w_we = accept && (32'(in_from) < MAX_NODES) && (32'(in_to) < MAX_NODES);
   assign w_wa = WIW'(32'(in_from) * MAX_NODES + 32'(in_to));
   assign w_ra = WIW'(32'(bu_ff) * MAX_NODES + 32'(bv_ff));

   always_ff @(posedge clock) begin
      if (w_we) weight_mem[w_wa] <= in_len;
      w_rd_ff <= weight_mem[w_ra];
   end

   always_ff @(posedge clock) begin
      if (reset || rsp_load) begin
         wvalid_ff <= '0;
      end else if (w_we) begin
         wvalid_ff[w_wa] <= 1'b1;
      end
      wv_rd_ff <= wvalid_ff[w_ra];
   end

   // build stage flags, registered alongside the weight read
   logic           bld_wr_ff, cp_wr_ff;
   logic           bld_j0_ff, bld_chain_ff, bld_diag_ff;
   logic [CIW-1:0] bld_k_ff;
   logic [AW-1:0]  wr_addr_ff;
   logic           bld_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         bld_wr_ff <= 1'b0;
         cp_wr_ff  <= 1'b0;
      end else begin
         bld_wr_ff <= (state_ff == wwcmp_pkg::ST_BUILD);
         cp_wr_ff  <= (state_ff == wwcmp_pkg::ST_CP_RUN);
      end
      bld_j0_ff    <= (bj_ff == '0);
      bld_chain_ff <= (32'(bj_ff) == 32'(bk_ff) + 1) && (bu_ff == bv_ff);
      bld_diag_ff  <= (r_ff == c_ff);
      bld_k_ff     <= bk_ff;
      wr_addr_ff   <= r_base_ff + AW'(c_ff);
   end

   assign bld_val = bld_j0_ff ? (wv_rd_ff && (5'(w_rd_ff) == 5'(bld_k_ff) + 5'd1))
                              : bld_chain_ff;

   // matrix memories
   logic [EW-1:0] base_mem    [DIM*DIM];
   logic [EW-1:0] power_mem   [DIM*DIM];
   logic [EW-1:0] scratch_mem [DIM*DIM];
   logic [EW-1:0] base_rd0_ff, base_rd1_ff, power_rd_ff, scratch_rd_ff;
   logic [AW-1:0] a_addr, b_addr, pw_ra, cp_ra;
   logic          base_we, power_we, scr_we;
   logic [EW-1:0] base_wd, power_wd, scr_wd;

   assign a_addr = r_base_ff + AW'(k_ff);
   assign b_addr = k_base_ff + AW'(c_ff);
   assign cp_ra  = r_base_ff + AW'(c_ff);
   assign pw_ra  = (state_ff == wwcmp_pkg::ST_RES_READ || state_ff == wwcmp_pkg::ST_RES_OUT)
                 ? AW'(n_last) : a_addr;

   assign base_we  = bld_wr_ff || (cp_wr_ff && op_sq_ff);
   assign power_we = bld_wr_ff || (cp_wr_ff && !op_sq_ff);
   assign base_wd  = bld_wr_ff ? EW'(bld_val) : scratch_rd_ff;
   assign power_wd = bld_wr_ff ? EW'(bld_diag_ff) : scratch_rd_ff;

   always_ff @(posedge clock) begin
      if (base_we) base_mem[wr_addr_ff] <= base_wd;
      base_rd0_ff <= base_mem[a_addr];
      base_rd1_ff <= base_mem[b_addr];
   end

   always_ff @(posedge clock) begin
      if (power_we) power_mem[wr_addr_ff] <= power_wd;
      power_rd_ff <= power_mem[pw_ra];
   end

   always_ff @(posedge clock) begin
      if (scr_we) scratch_mem[cp_ra] <= scr_wd;
      scratch_rd_ff <= scratch_mem[cp_ra];
   end

   // multiply-accumulate and modular reduction
   logic [wwcmp_pkg::PROD_W-1:0] prod_ff;
   logic [wwcmp_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic [wwcmp_pkg::RED_W-1:0]  red_ff;
   logic [wwcmp_pkg::ACC_W-1:0]  qm_ff;
   logic [wwcmp_pkg::ACC_W-1:0]  rem;
   logic [EW-1:0]                a_data;

   assign a_data = op_sq_ff ? base_rd0_ff : power_rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rv1_ff <= 1'b0;
         pv_ff  <= 1'b0;
      end else begin
         rv1_ff <= (state_ff == wwcmp_pkg::ST_MM_RUN);
         pv_ff  <= rv1_ff;
      end
      prod_ff <= a_data * base_rd1_ff;
      acc_ff  <= acc_in;
      red_ff  <= acc_ff * wwcmp_pkg::BARRETT_MUL;
      qm_ff   <= wwcmp_pkg::ACC_W'(red_ff[wwcmp_pkg::RED_W-1:wwcmp_pkg::BARRETT_SHIFT])
                 * wwcmp_pkg::ACC_W'(wwcmp_pkg::WALK_MOD_VAL);
   end

   always_comb begin
      acc_in = acc_ff;
      if (state_ff == wwcmp_pkg::ST_EXP_TOP || state_ff == wwcmp_pkg::ST_EXP_SHIFT
          || state_ff == wwcmp_pkg::ST_RED_WRITE)
         acc_in = '0;
      else if (pv_ff)
         acc_in = acc_ff + wwcmp_pkg::ACC_W'(prod_ff);
   end

   // estimate is low by at most one modulus
   always_comb begin
      rem = acc_ff - qm_ff;
      if (rem >= wwcmp_pkg::ACC_W'(wwcmp_pkg::WALK_MOD_VAL))
         rem = rem - wwcmp_pkg::ACC_W'(wwcmp_pkg::WALK_MOD_VAL);
   end

   assign scr_we = (state_ff == wwcmp_pkg::ST_RED_WRITE);
   assign scr_wd = rem[EW-1:0];

   // result register
   logic [EW-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) rsp_data_ff <= power_rd_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff};

endmodule
`default_nettype wire
